// ===== hdl/tabbt_pkg.sv =====
// Package for the triangular ABB^T + A^TA block.
// Holds the controller states, the MAC kinds, the command and status
// structs and the saturating add. It depends on nothing.
package tabbt_pkg;

    // Width of the matrix size register and its value after reset.
    localparam int SIZE_W = 7;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

    // Opcodes carried in the input tuser.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_ROW  = 1'b1;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_P_RUN,
        S_P_DRAIN,
        S_C1_RUN,
        S_C2_RUN,
        S_C_DRAIN,
        S_RD_ISSUE,
        S_RD_WAIT,
        S_RD_SEND
    } t_state;

    // What one MAC step does: build A*B, add AB*B^T, or add A^T*A.
    typedef enum logic [1:0] {
        K_P,
        K_C1,
        K_C2
    } t_kind;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  valid;
        t_kind kind;
        logic  first;
        logic  last;
        logic  load_we;
        logic  load_out;
        logic  last_col;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pipe_empty;
    } t_status;

    // 64-bit signed add that clips to the range; the top bit flags a clip.
    function automatic logic [64:0] sat_add(input logic signed [63:0] x,
                                            input logic signed [63:0] y);
        logic signed [63:0] s;
        s = x + y;
        if ((x[63] == y[63]) && (s[63] != x[63])) begin
            if (y[63]) begin
                return {1'b1, 64'h8000_0000_0000_0000};
            end else begin
                return {1'b1, 64'h7FFF_FFFF_FFFF_FFFF};
            end
        end
        return {1'b0, s};
    endfunction

endpackage

// ===== hdl/tabbt_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for every matrix store of the block. No dependencies.
module tabbt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write and one registered read each cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== hdl/tabbt_dp.sv =====
// Datapath: matrix stores, the single MAC pipeline and the output register.
// Depends on tabbt_pkg and tabbt_ram.
module tabbt_dp #(
    parameter int MAX_N = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  tabbt_pkg::t_cmd        i_cmd,
    input  logic [((MAX_N > 1) ? $clog2(MAX_N*MAX_N) : 1)-1:0] i_x_addr,
    input  logic [((MAX_N > 1) ? $clog2(MAX_N*MAX_N) : 1)-1:0] i_y_addr,
    input  logic [((MAX_N > 1) ? $clog2(MAX_N*MAX_N) : 1)-1:0] i_w_addr,
    input  logic [((MAX_N > 1) ? $clog2(MAX_N*MAX_N) : 1)-1:0] i_ld_addr,
    input  logic [((MAX_N > 1) ? $clog2(MAX_N*MAX_N) : 1)-1:0] i_rd_addr,
    input  logic [5:0]             i_col,
    input  logic [15:0]            i_a,
    input  logic [15:0]            i_b,
    output tabbt_pkg::t_status     o_status,
    output logic [63:0]            o_c_value,
    output logic [5:0]             o_column_index,
    output logic                   o_last_in_row,
    output logic                   o_saturated
);
    import tabbt_pkg::*;

    localparam int AW    = (MAX_N > 1) ? $clog2(MAX_N*MAX_N) : 1;
    localparam int DEPTH = MAX_N * MAX_N;

    logic [15:0] a_rd, a2_rd, b_rd;
    logic [39:0] p_rd;
    logic [64:0] res_rd;

    // Pipeline tags: stage 1 is the RAM read, stage 2 the product.
    logic          r1_v, r2_v, r4_v;
    t_kind         r1_kind, r2_kind;
    logic          r1_first, r2_first, r1_last, r2_last;
    logic [AW-1:0] r1_w, r2_w, r4_w;
    logic signed [55:0] r2_prod;

    // Accumulators and final-stage operands.
    logic signed [63:0] r_acc, r4_acc;
    logic               r_clip, r4_clip;
    logic signed [47:0] r_t, r4_t;

    logic signed [39:0] op1;
    logic signed [15:0] op2;
    logic signed [55:0] mul;
    logic signed [63:0] prod_ext, base_acc, sum_p;
    logic [64:0]        sat_c1, fin;
    logic signed [47:0] tsum;
    logic               clip_c1, p_we;
    logic [64:0]        res_wdata;

    // Output register.
    logic [63:0] r_out_c;
    logic [5:0]  r_out_col;
    logic        r_out_last, r_out_sat;

    // A is stored twice so that two of its elements are read in one cycle.
    tabbt_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_a_mem (
        .i_clk(i_clk), .i_we(i_cmd.load_we), .i_waddr(i_ld_addr), .i_wdata(i_a),
        .i_raddr(i_x_addr), .o_rdata(a_rd)
    );
    tabbt_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_a2_mem (
        .i_clk(i_clk), .i_we(i_cmd.load_we), .i_waddr(i_ld_addr), .i_wdata(i_a),
        .i_raddr(i_y_addr), .o_rdata(a2_rd)
    );
    tabbt_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_b_mem (
        .i_clk(i_clk), .i_we(i_cmd.load_we), .i_waddr(i_ld_addr), .i_wdata(i_b),
        .i_raddr(i_y_addr), .o_rdata(b_rd)
    );
    tabbt_ram #(.WIDTH(40), .DEPTH(DEPTH)) u_p_mem (
        .i_clk(i_clk), .i_we(p_we), .i_waddr(r2_w), .i_wdata(sum_p[39:0]),
        .i_raddr(i_x_addr), .o_rdata(p_rd)
    );
    tabbt_ram #(.WIDTH(65), .DEPTH(DEPTH)) u_res_mem (
        .i_clk(i_clk), .i_we(r4_v), .i_waddr(r4_w), .i_wdata(res_wdata),
        .i_raddr(i_rd_addr), .o_rdata(res_rd)
    );

    // Operand selection by kind after the RAM read.
    always_comb begin
        op1 = (r1_kind == K_C1) ? $signed(p_rd) : $signed({{24{a_rd[15]}}, a_rd});
        op2 = (r1_kind == K_C2) ? $signed(a2_rd) : $signed(b_rd);
        mul = op1 * op2;
    end

    // Accumulate stage.
    always_comb begin
        prod_ext = {{8{r2_prod[55]}}, r2_prod};
        base_acc = r2_first ? 64'sd0 : r_acc;
        sum_p    = base_acc + prod_ext;
        sat_c1   = sat_add(base_acc, prod_ext);
        clip_c1  = sat_c1[64] | (r2_first ? 1'b0 : r_clip);
        tsum     = (r2_first ? 48'sd0 : r_t) + r2_prod[47:0];
        p_we     = r2_v && (r2_kind == K_P) && r2_last;
    end

    // Final stage: add A^T*A scaled by 256 into the clipped sum.
    always_comb begin
        fin       = sat_add(r4_acc, {{8{r4_t[47]}}, r4_t, 8'h00});
        res_wdata = {r4_clip | fin[64], fin[63:0]};
    end

    // Pipeline valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r4_v <= 1'b0;
        end else begin
            r1_v <= i_cmd.valid;
            r2_v <= r1_v;
            r4_v <= r2_v && (r2_kind == K_C2) && r2_last;
        end
    end

    // Pipeline payload and accumulators.
    always_ff @(posedge i_clk) begin
        r1_kind  <= i_cmd.kind;
        r1_first <= i_cmd.first;
        r1_last  <= i_cmd.last;
        r1_w     <= i_w_addr;
        r2_kind  <= r1_kind;
        r2_first <= r1_first;
        r2_last  <= r1_last;
        r2_w     <= r1_w;
        r2_prod  <= mul;
        if (r2_v) begin
            unique case (r2_kind)
                K_P: begin
                    r_acc <= sum_p;
                end
                K_C1: begin
                    r_acc  <= $signed(sat_c1[63:0]);
                    r_clip <= clip_c1;
                end
                K_C2: begin
                    r_t <= tsum;
                end
                default: begin
                    r_t <= r_t;
                end
            endcase
        end
        r4_acc  <= r_acc;
        r4_clip <= r_clip;
        r4_t    <= tsum;
        r4_w    <= r2_w;
    end

    // Output register, loaded from the result store.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_c    <= res_rd[63:0];
            r_out_sat  <= res_rd[64];
            r_out_col  <= i_col;
            r_out_last <= i_cmd.last_col;
        end
    end

    assign o_status.pipe_empty = !(r1_v || r2_v || r4_v);
    assign o_c_value      = r_out_c;
    assign o_column_index = r_out_col;
    assign o_last_in_row  = r_out_last;
    assign o_saturated    = r_out_sat;
endmodule

// ===== hdl/tabbt_ctrl.sv =====
// Controller: handshakes, load counter, matrix size and the loop sequencer
// that drives the MAC pipeline and the row readout. Depends on tabbt_pkg.
module tabbt_ctrl #(
    parameter int MAX_N = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic                   i_opcode,
    input  logic [5:0]             i_row,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [tabbt_pkg::SIZE_W-1:0] i_cfg_data,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output tabbt_pkg::t_cmd        o_cmd,
    output logic [((MAX_N > 1) ? $clog2(MAX_N*MAX_N) : 1)-1:0] o_x_addr,
    output logic [((MAX_N > 1) ? $clog2(MAX_N*MAX_N) : 1)-1:0] o_y_addr,
    output logic [((MAX_N > 1) ? $clog2(MAX_N*MAX_N) : 1)-1:0] o_w_addr,
    output logic [((MAX_N > 1) ? $clog2(MAX_N*MAX_N) : 1)-1:0] o_ld_addr,
    output logic [((MAX_N > 1) ? $clog2(MAX_N*MAX_N) : 1)-1:0] o_rd_addr,
    output logic [5:0]             o_col,
    input  tabbt_pkg::t_status     i_status
);
    import tabbt_pkg::*;

    localparam int AW = (MAX_N > 1) ? $clog2(MAX_N*MAX_N) : 1;
    localparam int NW = $clog2(MAX_N + 1);
    localparam int CW = $clog2(MAX_N*MAX_N + 1);

    t_state              r_state, n_state;
    logic [SIZE_W-1:0]   r_size, n_size;
    logic [CW-1:0]       r_load_count, n_load_count;
    logic                r_ready, n_ready;
    logic [NW-1:0]       r_i, r_j, r_k, n_i, n_j, n_k;
    logic [5:0]          r_row, n_row;

    logic [NW-1:0] n_eff, n_last, lim;
    logic [CW-1:0] total;
    logic          s_acc, cfg_acc, full, row_ok, is_load, is_row;

    // Row-major address of element (r, c).
    function automatic logic [AW-1:0] mkaddr(input logic [NW-1:0] r,
                                             input logic [NW-1:0] c,
                                             input logic [NW-1:0] n);
        logic [2*NW-1:0] p;
        p = (2*NW)'(r) * (2*NW)'(n) + (2*NW)'(c);
        return AW'(p);
    endfunction

    // Effective size, clamped to 1..MAX_N.
    always_comb begin
        if (r_size == '0) begin
            n_eff = NW'(1);
        end else if (int'(r_size) > MAX_N) begin
            n_eff = NW'(MAX_N);
        end else begin
            n_eff = NW'(r_size);
        end
        n_last  = n_eff - NW'(1);
        total   = CW'((2*NW)'(n_eff) * (2*NW)'(n_eff));
        lim     = (r_i < r_j) ? r_i : r_j;
        s_acc   = i_s_tvalid && o_s_tready;
        cfg_acc = i_cfg_valid && o_cfg_ready;
        full    = (r_load_count >= total);
        row_ok  = int'(i_row) < int'(n_eff);
        is_load = s_acc && (i_opcode == OP_LOAD);
        is_row  = s_acc && (i_opcode == OP_ROW) && full && row_ok;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (is_row) begin
                    n_state = r_ready ? S_RD_ISSUE : S_P_RUN;
                end
            end
            S_P_RUN: begin
                if (r_k == n_last && r_j == n_last && r_i == n_last) begin
                    n_state = S_P_DRAIN;
                end
            end
            S_P_DRAIN: begin
                if (i_status.pipe_empty) begin
                    n_state = S_C1_RUN;
                end
            end
            S_C1_RUN: begin
                if (r_k == n_last) begin
                    n_state = S_C2_RUN;
                end
            end
            S_C2_RUN: begin
                if (r_k == lim) begin
                    n_state = (r_i == n_last && r_j == n_last) ? S_C_DRAIN : S_C1_RUN;
                end
            end
            S_C_DRAIN: begin
                if (i_status.pipe_empty) begin
                    n_state = S_RD_ISSUE;
                end
            end
            S_RD_ISSUE: begin
                n_state = S_RD_WAIT;
            end
            S_RD_WAIT: begin
                n_state = S_RD_SEND;
            end
            S_RD_SEND: begin
                if (i_m_tready) begin
                    n_state = (r_j == n_last) ? S_IDLE : S_RD_ISSUE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Loop counters, load count, size and the result flag.
    always_comb begin
        n_i          = r_i;
        n_j          = r_j;
        n_k          = r_k;
        n_row        = r_row;
        n_size       = r_size;
        n_load_count = r_load_count;
        n_ready      = r_ready;
        if (cfg_acc) begin
            n_size       = i_cfg_data;
            n_load_count = '0;
            n_ready      = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (is_load) begin
                    n_load_count = full ? CW'(1) : r_load_count + CW'(1);
                    n_ready      = 1'b0;
                end
                if (is_row) begin
                    n_i   = '0;
                    n_j   = '0;
                    n_k   = '0;
                    n_row = i_row;
                end
            end
            S_P_RUN: begin
                if (r_k == n_last) begin
                    if (r_j == n_last) begin
                        n_j = '0;
                        if (r_i == n_last) begin
                            n_i = '0;
                            n_k = '0;
                        end else begin
                            n_i = r_i + NW'(1);
                            n_k = r_i + NW'(1);
                        end
                    end else begin
                        n_j = r_j + NW'(1);
                        n_k = r_i;
                    end
                end else begin
                    n_k = r_k + NW'(1);
                end
            end
            S_C1_RUN: begin
                n_k = (r_k == n_last) ? '0 : r_k + NW'(1);
            end
            S_C2_RUN: begin
                if (r_k == lim) begin
                    n_k = '0;
                    if (r_j == n_last) begin
                        n_j = '0;
                        n_i = (r_i == n_last) ? '0 : r_i + NW'(1);
                    end else begin
                        n_j = r_j + NW'(1);
                    end
                end else begin
                    n_k = r_k + NW'(1);
                end
            end
            S_C_DRAIN: begin
                if (i_status.pipe_empty) begin
                    n_ready = 1'b1;
                end
            end
            S_RD_SEND: begin
                if (i_m_tready && r_j != n_last) begin
                    n_j = r_j + NW'(1);
                end
            end
            default: begin
                n_k = r_k;
            end
        endcase
    end

    // Outputs: handshakes, MAC commands and addresses.
    always_comb begin
        o_cmd       = '0;
        o_cmd.kind  = K_P;
        o_s_tready  = (r_state == S_IDLE) && !i_cfg_valid;
        o_cfg_ready = (r_state == S_IDLE);
        o_m_tvalid  = (r_state == S_RD_SEND);
        o_x_addr    = mkaddr(r_i, r_k, n_eff);
        o_y_addr    = mkaddr(r_k, r_j, n_eff);
        o_w_addr    = mkaddr(r_i, r_j, n_eff);
        o_ld_addr   = full ? '0 : AW'(r_load_count);
        o_rd_addr   = mkaddr(NW'(r_row), r_j, n_eff);
        o_col       = 6'(r_j);
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load_we = is_load;
            end
            S_P_RUN: begin
                o_cmd.valid = 1'b1;
                o_cmd.kind  = K_P;
                o_cmd.first = (r_k == r_i);
                o_cmd.last  = (r_k == n_last);
            end
            S_C1_RUN: begin
                o_cmd.valid = 1'b1;
                o_cmd.kind  = K_C1;
                o_cmd.first = (r_k == '0);
                o_y_addr    = mkaddr(r_j, r_k, n_eff);
            end
            S_C2_RUN: begin
                o_cmd.valid = 1'b1;
                o_cmd.kind  = K_C2;
                o_cmd.first = (r_k == '0);
                o_cmd.last  = (r_k == lim);
                o_x_addr    = mkaddr(r_k, r_i, n_eff);
            end
            S_RD_WAIT: begin
                o_cmd.load_out = 1'b1;
                o_cmd.last_col = (r_j == n_last);
            end
            default: begin
                o_cmd.valid = 1'b0;
            end
        endcase
    end

    // Registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_size       <= SIZE_RESET;
            r_load_count <= '0;
            r_ready      <= 1'b0;
            r_i          <= '0;
            r_j          <= '0;
            r_k          <= '0;
        end else begin
            r_state      <= n_state;
            r_size       <= n_size;
            r_load_count <= n_load_count;
            r_ready      <= n_ready;
            r_i          <= n_i;
            r_j          <= n_j;
            r_k          <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row <= n_row;
    end

`ifndef NO_ASSERTIONS
    // A size write restarts loading and drops the computed result.
    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_acc |=> (r_load_count == '0) && !r_ready)
        else $error("size write did not restart loading");

    // The load count never runs past a full matrix.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_load_count <= total)
        else $error("load count beyond matrix");

    // A row is only sent out of a computed result.
    a_send_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD_SEND) |-> r_ready)
        else $error("row sent without a computed result");

    // The result becomes ready only once the pipeline has drained.
    a_ready_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ready) |-> ($past(r_state) == S_C_DRAIN))
        else $error("result ready outside drain");
`endif
endmodule

// ===== hdl/triangular_abbt_plus_ata.sv =====
// Top level of the triangular ABB^T + A^TA block.
// Depends on tabbt_pkg, tabbt_ctrl and tabbt_dp.
//
// A load item (tuser 0) stores one A,B pair in row-major order. A row
// request (tuser 1) after a full N*N load sends N items of that row of C;
// requests before a full load or for a row not below N give no items. The
// first request after a load computes all of C with one MAC unit: first A*B,
// then AB*B^T and A^T*A, then the pipeline drain; later requests skip this.
// Each result item passes through the result RAM read port and the output
// register before the next one is read. Writing the size restarts loading.
// No reset sweep is run.
module triangular_abbt_plus_ata #(
    parameter int MAX_N = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input items.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,  // a_value[15:0], b_value[31:16], row_index[37:32]
    input  logic        i_s_tuser,  // opcode
    // Result items.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata,  // c_value[63:0], column_index[69:64]
    output logic        o_m_tlast,  // last_in_row
    output logic        o_m_tuser,  // saturated
    // Size register write.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [6:0]  i_cfg_data
);
    import tabbt_pkg::*;

    localparam int AW = (MAX_N > 1) ? $clog2(MAX_N*MAX_N) : 1;

    t_cmd          cmd;
    t_status       status;
    logic [AW-1:0] x_addr, y_addr, w_addr, ld_addr, rd_addr;
    logic [5:0]    col, out_col;
    logic [63:0]   c_value;

    tabbt_ctrl #(.MAX_N(MAX_N)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_opcode   (i_s_tuser),
        .i_row      (i_s_tdata[37:32]),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (cmd),
        .o_x_addr   (x_addr),
        .o_y_addr   (y_addr),
        .o_w_addr   (w_addr),
        .o_ld_addr  (ld_addr),
        .o_rd_addr  (rd_addr),
        .o_col      (col),
        .i_status   (status)
    );

    tabbt_dp #(.MAX_N(MAX_N)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_x_addr      (x_addr),
        .i_y_addr      (y_addr),
        .i_w_addr      (w_addr),
        .i_ld_addr     (ld_addr),
        .i_rd_addr     (rd_addr),
        .i_col         (col),
        .i_a           (i_s_tdata[15:0]),
        .i_b           (i_s_tdata[31:16]),
        .o_status      (status),
        .o_c_value     (c_value),
        .o_column_index(out_col),
        .o_last_in_row (o_m_tlast),
        .o_saturated   (o_m_tuser)
    );

    // Pack the result fields, padded to whole bytes.
    assign o_m_tdata = {2'b00, out_col, c_value};
endmodule

// ===== tb/triangular_abbt_plus_ata_tb.sv =====
// Testbench for triangular_abbt_plus_ata: loads A,B pairs, requests rows of C and
// checks every result item against a bit-exact predictor held in the bench.
// Depends on tabbt_pkg and the triangular_abbt_plus_ata RTL.
module triangular_abbt_plus_ata_tb;
    import tabbt_pkg::*;

    localparam int MAXN  = 64;
    localparam int CELLS = MAXN * MAXN;
    localparam int LIMIT = 400000;

    typedef struct {
        logic               op;
        logic signed [15:0] a;
        logic signed [15:0] b;
        logic [5:0]         row;
    } t_item;

    typedef struct {
        logic signed [63:0] c;
        logic [5:0]         col;
        logic               last;
        logic               sat;
    } t_elem;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [39:0] i_s_tdata = '0;   // a_value[15:0], b_value[31:16], row_index[37:32]
    logic        i_s_tuser = 1'b0; // opcode
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [71:0] o_m_tdata;        // c_value[63:0], column_index[69:64]
    logic        o_m_tlast;
    logic        o_m_tuser;        // saturated
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [6:0]  i_cfg_data = '0;

    triangular_abbt_plus_ata #(.MAX_N(MAXN)) dut (.*);

    // Clock.
    always #5 i_clk = ~i_clk;

    // Predictor state.
    logic signed [15:0] a_mem [CELLS];
    logic signed [15:0] b_mem [CELLS];
    logic signed [63:0] ab_mem [CELLS];
    logic signed [63:0] c_mem [CELLS];
    logic               clip_mem [CELLS];
    int unsigned        loaded;
    logic               c_valid;
    logic [6:0]         size_reg;

    t_item pending_q[$];
    t_elem c_expect[$];
    t_item drv_item;
    int    src_idle_pct = 0;
    int    snk_stall_pct = 0;
    int    errors = 0;
    int    cycles = 0;

    function automatic int unsigned eff_size();
        if (size_reg < 1) return 1;
        if (size_reg > MAXN) return MAXN;
        return size_reg;
    endfunction

    // Adds with clipping to the 64-bit range and raises the clip flag.
    function automatic logic signed [63:0] clip_add(input logic signed [63:0] x,
                                                    input logic signed [63:0] y,
                                                    inout logic clip);
        logic signed [63:0] s;
        s = x + y;
        if (x[63] == y[63] && s[63] != x[63]) begin
            clip = 1'b1;
            s = y[63] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
        end
        return s;
    endfunction

    // Builds all of C from the stored A and B.
    function automatic void build_c(input int unsigned n);
        logic signed [63:0] s, acc, t;
        logic clip;
        int unsigned lim;
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
                s = 0;
                for (int k = i; k < n; k++)
                    s += 64'(a_mem[i*n+k]) * 64'(b_mem[k*n+j]);
                ab_mem[i*n+j] = s;
            end
        end
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
                acc = 0;
                t = 0;
                clip = 1'b0;
                lim = (i < j) ? i : j;
                for (int k = 0; k < n; k++)
                    acc = clip_add(acc, ab_mem[i*n+k] * 64'(b_mem[j*n+k]), clip);
                for (int k = 0; k <= lim; k++)
                    t += 64'(a_mem[k*n+i]) * 64'(a_mem[k*n+j]);
                acc = clip_add(acc, t * 256, clip);
                c_mem[i*n+j] = acc;
                clip_mem[i*n+j] = clip;
            end
        end
    endfunction

    // Updates the predictor for one accepted item and queues the row it yields.
    function automatic void predict_item(input t_item it);
        int unsigned n, total;
        t_elem e;
        n = eff_size();
        total = n * n;
        if (it.op == OP_LOAD) begin
            if (loaded >= total) loaded = 0;
            a_mem[loaded] = it.a;
            b_mem[loaded] = it.b;
            loaded++;
            c_valid = 1'b0;
            return;
        end
        if (loaded < total || it.row >= n) return;
        if (!c_valid) begin
            build_c(n);
            c_valid = 1'b1;
        end
        for (int j = 0; j < n; j++) begin
            e.c = c_mem[it.row*n+j];
            e.col = j[5:0];
            e.last = (j + 1 == n);
            e.sat = clip_mem[it.row*n+j];
            c_expect.push_back(e);
        end
    endfunction

    // Driver: presents queued items, predicts each one as it is accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) predict_item(drv_item);
            if (!i_s_tvalid || o_s_tready) begin
                if (pending_q.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                    drv_item = pending_q.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata <= {2'b00, drv_item.row, drv_item.b, drv_item.a};
                    i_s_tuser <= drv_item.op;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random back-pressure and comparison of each result item.
    always @(posedge i_clk) begin
        t_elem e;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (c_expect.size() == 0) begin
                $display("%0t: unexpected item c=%h col=%0d", $time,
                         o_m_tdata[63:0], o_m_tdata[69:64]);
                errors++;
            end else begin
                e = c_expect.pop_front();
                if (o_m_tdata[63:0] !== e.c || o_m_tdata[69:64] !== e.col ||
                    o_m_tlast !== e.last || o_m_tuser !== e.sat) begin
                    $display("%0t: mismatch expected c=%h col=%0d last=%b sat=%b, got c=%h col=%0d last=%b sat=%b",
                             $time, e.c, e.col, e.last, e.sat, o_m_tdata[63:0],
                             o_m_tdata[69:64], o_m_tlast, o_m_tuser);
                    errors++;
                end
            end
        end
        i_m_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Waits until all items are sent and all expected results are seen, then lets the block settle.
    task automatic drain();
        do @(posedge i_clk);
        while (pending_q.size() > 0 || i_s_tvalid || c_expect.size() > 0);
        repeat (30) @(posedge i_clk);
    endtask

    // Writes the size register; only called while the block is idle.
    task automatic write_size(input logic [6:0] v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        size_reg = v;
        loaded = 0;
        c_valid = 1'b0;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic void push_load(input logic [15:0] a, input logic [15:0] b);
        t_item it;
        it.op = OP_LOAD;
        it.a = a;
        it.b = b;
        it.row = 6'($urandom_range(0, 63));
        pending_q.push_back(it);
    endfunction

    function automatic void push_row(input logic [5:0] r);
        t_item it;
        it.op = OP_ROW;
        it.a = 16'($urandom);
        it.b = 16'($urandom);
        it.row = r;
        pending_q.push_back(it);
    endfunction

    // Stimulus.
    initial begin
        int n;
        size_reg = 7'd64;
        loaded = 0;
        c_valid = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: one-element matrix, early and out-of-range requests, reload.
        write_size(7'd1);
        push_row(6'd0);
        push_load(16'h8000, 16'h7FFF);
        push_row(6'd0);
        push_row(6'd1);
        push_row(6'd63);
        push_load(16'h7FFF, 16'h8000);
        push_row(6'd0);
        drain();
        // A size of zero acts as one.
        write_size(7'd0);
        push_load(16'hFFFF, 16'h0000);
        push_row(6'd0);
        drain();
        // Three by three with extreme values, including the ignored lower part of A.
        write_size(7'd3);
        for (int k = 0; k < 9; k++)
            push_load((k % 2) ? 16'h7FFF : 16'h8000, (k % 3) ? 16'h8000 : 16'h7FFF);
        push_row(6'd2);
        push_row(6'd0);
        push_row(6'd1);
        push_row(6'd3);
        drain();
        // Largest sizes: written and partly loaded, so requests stay ignored.
        write_size(7'd127);
        push_load(16'h1234, 16'hFEDC);
        push_row(6'd0);
        drain();
        write_size(7'd64);
        push_load(16'h0100, 16'h0100);
        push_row(6'd63);
        drain();

        // Random phases with different idling.
        for (int ph = 0; ph < 4; ph++) begin
            src_idle_pct  = (ph == 1) ? 49 : (ph == 3) ? 18 : 0;
            snk_stall_pct = (ph == 2) ? 49 : (ph == 3) ? 18 : 0;
            for (int m = 0; m < 2; m++) begin
                n = $urandom_range(2, 5);
                write_size(7'(n));
                if ($urandom_range(0, 3) == 0) push_row(6'($urandom_range(0, 63)));
                for (int k = 0; k < n * n; k++)
                    push_load(16'($urandom), 16'($urandom));
                for (int r = 0; r < n; r++)
                    push_row(($urandom_range(0, 5) == 0) ? 6'($urandom_range(0, 63))
                                                         : 6'($urandom_range(0, n - 1)));
                // Sometimes restart with a fresh matrix without writing the size.
                if ($urandom_range(0, 1) == 0) begin
                    for (int k = 0; k < n * n; k++)
                        push_load(16'($urandom), 16'($urandom));
                    push_row(6'($urandom_range(0, n - 1)));
                end
                drain();
            end
        end

        src_idle_pct = 0;
        snk_stall_pct = 0;
        drain();
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
